// ----- hw/rtl/slkft_pkg.sv -----
// Shared item types and request/status codes for the slot-keyed framing table.
package slkft_pkg;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_STORE  = 2'd1;
    localparam logic [1:0] REQ_FORGET = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_BADKEY = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam int SLOT_W  = 8;
    localparam int KEY_W   = 32;
    localparam int FRAME_W = 64;
    localparam int COUNT_W = 6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [SLOT_W-1:0]  slot;
        logic [KEY_W-1:0]   source_key;
        logic               key_valid;
        logic [FRAME_W-1:0] framing_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] framing_out;
        logic [COUNT_W-1:0] entry_count;
    } t_out_item;

endpackage

// ----- hw/rtl/slkft_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module slkft_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/slot_keyed_framing_table_core.sv -----
// Top level of the slot-keyed framing table: request sequencer around one entry RAM.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  request | in        | i_in_valid / o_in_stall   | i_in  (slkft_pkg::t_in_item)
//  result  | out       | o_out_valid / i_out_stall | o_out (slkft_pkg::t_out_item)
//
// One item at a time: the input stalls until the sequencer is back in idle. Lookup and
// store scan the used entries linearly, reading one RAM entry per cycle. Forget reads
// each used entry in turn; on a match it reads the last entry and writes it into the
// hole, then checks that position again (a match on the last entry just shrinks the
// table). Clear and bad-key requests go straight to the response state.
// Reset clears the sequencer, the entry count and the output valid flag only; the RAM
// needs no clearing pass since no entry at or above the count is ever read.
// Stalls: a result waits in the output register; the next item is accepted meanwhile,
// and its result holds in the response state until the output register frees up.
module slot_keyed_framing_table_core #(
    parameter int RECORDS      = 32,
    parameter int KEY_BITS     = 32,
    parameter int FRAMING_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  slkft_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output slkft_pkg::t_out_item o_out
);

    // Only the low 32 bits of the key field exist at the port.
    localparam int KW = (KEY_BITS < slkft_pkg::KEY_W) ? KEY_BITS : slkft_pkg::KEY_W;
    localparam int FB = FRAMING_BITS;
    localparam int EW = slkft_pkg::SLOT_W + KW + FB;
    localparam int AW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int CW = $clog2(RECORDS + 1);

    typedef logic [CW-1:0] t_cnt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FRD,
        S_FCHK,
        S_FMOVE,
        S_RESP
    } t_state;

    t_state               r_state, n_state;
    t_cnt                 r_used,  n_used;
    t_cnt                 r_idx,   n_idx;
    t_cnt                 r_chk,   n_chk;
    logic                 r_pend,  n_pend;
    logic                 r_removed, n_removed;
    slkft_pkg::t_in_item  r_req,   n_req;
    logic [1:0]           r_status, n_status;
    logic [slkft_pkg::FRAME_W-1:0] r_fout, n_fout;
    logic                 r_out_valid, n_out_valid;
    slkft_pkg::t_out_item r_out,   n_out;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [EW-1:0]        rd_data;

    logic [slkft_pkg::SLOT_W-1:0] e_slot;
    logic [KW-1:0]        e_key;
    logic [FB-1:0]        e_frame;
    logic [KW-1:0]        req_key;
    logic                 hit;
    logic                 in_acc;
    t_cnt                 last_idx;
    t_cnt                 nxt_idx;

    // Entry layout: slot on top, then key, then framing payload.
    slkft_ram #(
        .WIDTH     (EW),
        .DEPTH     (RECORDS),
        .ADDR_BITS (AW)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign e_slot  = rd_data[EW-1 -: slkft_pkg::SLOT_W];
    assign e_key   = rd_data[FB +: KW];
    assign e_frame = rd_data[FB-1:0];
    assign req_key = r_req.source_key[KW-1:0];

    // The read data matches the request only when a scan read was issued last cycle.
    assign hit      = r_pend && (e_slot == r_req.slot) && (e_key == req_key);
    assign last_idx = r_used - t_cnt'(1);
    assign nxt_idx  = r_idx + t_cnt'(1);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_chk       = r_chk;
        n_pend      = 1'b0;
        n_removed   = r_removed;
        n_req       = r_req;
        n_status    = r_status;
        n_fout      = r_fout;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        // Drop the delivered result; the response state may refill it below.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req     = i_in;
                    n_idx     = '0;
                    n_removed = 1'b0;
                    n_fout    = '0;
                    case (i_in.req_type)
                        slkft_pkg::REQ_LOOKUP, slkft_pkg::REQ_STORE: begin
                            if (!i_in.key_valid) begin
                                n_status = slkft_pkg::ST_BADKEY;
                                n_state  = S_RESP;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        slkft_pkg::REQ_FORGET: begin
                            n_state = S_FRD;
                        end
                        default: begin
                            n_used   = '0;
                            n_status = slkft_pkg::ST_OK;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (hit) begin
                    n_status = slkft_pkg::ST_OK;
                    if (r_req.req_type == slkft_pkg::REQ_LOOKUP) begin
                        n_fout = slkft_pkg::FRAME_W'(e_frame);
                    end else begin
                        // Update the payload in place.
                        wr_en   = 1'b1;
                        wr_addr = r_chk[AW-1:0];
                        wr_data = {r_req.slot, req_key, r_req.framing_in[FB-1:0]};
                    end
                    n_state = S_RESP;
                end else if (r_idx < r_used) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_chk   = r_idx;
                    n_idx   = nxt_idx;
                    n_pend  = 1'b1;
                end else begin
                    if (r_req.req_type == slkft_pkg::REQ_LOOKUP) begin
                        n_status = slkft_pkg::ST_MISS;
                    end else if (r_used >= t_cnt'(RECORDS)) begin
                        n_status = slkft_pkg::ST_FULL;
                    end else begin
                        // Append at the end of the table.
                        wr_en    = 1'b1;
                        wr_addr  = r_used[AW-1:0];
                        wr_data  = {r_req.slot, req_key, r_req.framing_in[FB-1:0]};
                        n_used   = r_used + t_cnt'(1);
                        n_status = slkft_pkg::ST_OK;
                    end
                    n_state = S_RESP;
                end
            end

            S_FRD: begin
                if (r_idx < r_used) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx[AW-1:0];
                    n_state = S_FCHK;
                end else begin
                    n_status = r_removed ? slkft_pkg::ST_OK : slkft_pkg::ST_MISS;
                    n_state  = S_RESP;
                end
            end

            S_FCHK: begin
                if (e_slot == r_req.slot) begin
                    n_removed = 1'b1;
                    if (r_idx == last_idx) begin
                        // Hole is the last entry: just shrink.
                        n_used  = last_idx;
                        n_state = S_FRD;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = last_idx[AW-1:0];
                        n_state = S_FMOVE;
                    end
                end else begin
                    n_idx = nxt_idx;
                    if (nxt_idx < r_used) begin
                        rd_en   = 1'b1;
                        rd_addr = nxt_idx[AW-1:0];
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end

            S_FMOVE: begin
                // Move the last entry into the hole, then check that position again.
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                wr_data = rd_data;
                n_used  = last_idx;
                n_state = S_FRD;
            end

            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.framing_out = r_fout;
                    n_out.entry_count = slkft_pkg::COUNT_W'(r_used);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_idx     <= n_idx;
        r_chk     <= n_chk;
        r_removed <= n_removed;
        r_req     <= n_req;
        r_status  <= n_status;
        r_fout    <= n_fout;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The count never passes the table size.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= t_cnt'(RECORDS))
        else $error("entry count above table size");

    // A clear empties the table right away.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.req_type == slkft_pkg::REQ_CLEAR)) |=> (r_used == '0))
        else $error("clear left entries in use");

    // Writes land inside the used region or append right at its end.
    a_write_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (t_cnt'(wr_addr) <= r_used))
        else $error("entry write outside used region");

    // A forget step never grows the table.
    a_forget_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FCHK) || (r_state == S_FMOVE)) |=> (r_used <= $past(r_used)))
        else $error("forget grew the table");

endmodule

// ----- tb/sv/slkft_checker.sv -----
// Channel monitor and behavioral table model that scores every result of the core.
module slkft_checker #(
    parameter int RECORDS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  slkft_pkg::t_in_item  i_in,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  slkft_pkg::t_out_item i_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [slkft_pkg::SLOT_W-1:0]  entry_slot  [RECORDS];
    logic [slkft_pkg::KEY_W-1:0]   entry_key   [RECORDS];
    logic [slkft_pkg::FRAME_W-1:0] entry_frame [RECORDS];
    int                            entry_used = 0;
    slkft_pkg::t_out_item          owed_results [$];
    int                            mismatches = 0;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [79:0] got,
                                   input logic [79:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    function automatic int find_entry(input logic [slkft_pkg::SLOT_W-1:0] slot,
                                      input logic [slkft_pkg::KEY_W-1:0] key);
        for (int i = 0; i < entry_used; i++)
            if (entry_slot[i] == slot && entry_key[i] == key)
                return i;
        return -1;
    endfunction

    // Apply one request to the model table and return the result it owes.
    function automatic slkft_pkg::t_out_item serve_request(input slkft_pkg::t_in_item req);
        slkft_pkg::t_out_item res;
        int                   hit;
        int                   pos;
        bit                   dropped;
        res        = '0;
        res.status = slkft_pkg::ST_OK;
        case (req.req_type)
            slkft_pkg::REQ_LOOKUP, slkft_pkg::REQ_STORE: begin
                hit = find_entry(req.slot, req.source_key);
                if (!req.key_valid) begin
                    res.status = slkft_pkg::ST_BADKEY;
                end else if (req.req_type == slkft_pkg::REQ_LOOKUP) begin
                    if (hit < 0)
                        res.status = slkft_pkg::ST_MISS;
                    else
                        res.framing_out = entry_frame[hit];
                end else if (hit >= 0) begin
                    entry_frame[hit] = req.framing_in;
                end else if (entry_used >= RECORDS) begin
                    res.status = slkft_pkg::ST_FULL;
                end else begin
                    entry_slot[entry_used]  = req.slot;
                    entry_key[entry_used]   = req.source_key;
                    entry_frame[entry_used] = req.framing_in;
                    entry_used++;
                end
            end
            slkft_pkg::REQ_FORGET: begin
                // Move the last entry into the hole, then look at the hole again.
                pos     = 0;
                dropped = 1'b0;
                while (pos < entry_used) begin
                    if (entry_slot[pos] == req.slot) begin
                        entry_slot[pos]  = entry_slot[entry_used-1];
                        entry_key[pos]   = entry_key[entry_used-1];
                        entry_frame[pos] = entry_frame[entry_used-1];
                        entry_used--;
                        dropped = 1'b1;
                    end else begin
                        pos++;
                    end
                end
                res.status = dropped ? slkft_pkg::ST_OK : slkft_pkg::ST_MISS;
            end
            default: begin
                entry_used = 0;
            end
        endcase
        res.entry_count = slkft_pkg::COUNT_W'(entry_used);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        slkft_pkg::t_out_item want;
        if (!i_rst_n) begin
            entry_used = 0;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with nothing owed", i_out, '0);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out.status !== want.status)
                        report_mismatch("status", i_out.status, want.status);
                    if (i_out.framing_out !== want.framing_out)
                        report_mismatch("framing_out", i_out.framing_out, want.framing_out);
                    if (i_out.entry_count !== want.entry_count)
                        report_mismatch("entry_count", i_out.entry_count, want.entry_count);
                end
            end
            if (i_in_valid && !i_in_stall)
                owed_results.push_back(serve_request(i_in));
        end
        o_pending    <= owed_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the framing table bench: clock, reset, request traffic, result stalls and verdict.
module tb_top;

    localparam int RECORDS      = 32;
    localparam int RANDOM_ITEMS = 950;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 400;
    localparam int DRAIN_CYCLES = 4 * RECORDS + 16;
    localparam int RECENT_DEPTH = 16;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    slkft_pkg::t_in_item  in_item   = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    slkft_pkg::t_out_item out_item;
    int                   fail_count;
    int                   pending;
    int                   items_sent = 0;
    int                   burst_left = 0;

    // Most traffic lands on a few slots and keys so that hits, updates and
    // multi-entry forgets happen often; the rest spreads over the full range.
    logic [slkft_pkg::SLOT_W-1:0] slot_pool [5] = '{8'd0, 8'd1, 8'd2, 8'd170, 8'd255};
    logic [slkft_pkg::KEY_W-1:0]  key_pool  [8];
    // Pairs stored lately, so lookups mostly ask for something that may be there.
    logic [slkft_pkg::SLOT_W-1:0] recent_slot [$];
    logic [slkft_pkg::KEY_W-1:0]  recent_key  [$];

    slot_keyed_framing_table_core #(
        .RECORDS      (RECORDS),
        .KEY_BITS     (slkft_pkg::KEY_W),
        .FRAMING_BITS (slkft_pkg::FRAME_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    slkft_checker #(
        .RECORDS (RECORDS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the core hangs or a result never shows up.
    initial begin : watchdog
        #2_000_000;
        $display("slot_keyed_framing_table_core test failed");
        $finish;
    end

    function automatic slkft_pkg::t_in_item make_req(
            input logic [1:0]                  req_type,
            input logic [slkft_pkg::SLOT_W-1:0]  slot,
            input logic [slkft_pkg::KEY_W-1:0]   key,
            input logic                        key_valid,
            input logic [slkft_pkg::FRAME_W-1:0] frame);
        slkft_pkg::t_in_item req;
        req.req_type   = req_type;
        req.slot       = slot;
        req.source_key = key;
        req.key_valid  = key_valid;
        req.framing_in = frame;
        return req;
    endfunction

    function automatic logic [slkft_pkg::SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 9) < 7)
            return slot_pool[$urandom_range(0, 4)];
        return slkft_pkg::SLOT_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [slkft_pkg::KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic logic [slkft_pkg::FRAME_W-1:0] rand_frame();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly valid keys; the odd invalid one must leave the table alone.
    function automatic logic key_ok();
        return $urandom_range(0, 9) != 0;
    endfunction

    // Offer one item and hold it until the core takes it. Valid stays up
    // between items of a burst; drop it only for the gap before a new burst.
    task automatic send_request(input slkft_pkg::t_in_item req);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic remember_pair(input logic [slkft_pkg::SLOT_W-1:0] slot,
                                 input logic [slkft_pkg::KEY_W-1:0] key);
        recent_slot.push_back(slot);
        recent_key.push_back(key);
        if (recent_slot.size() > RECENT_DEPTH) begin
            void'(recent_slot.pop_front());
            void'(recent_key.pop_front());
        end
    endtask

    task automatic pick_known(output logic [slkft_pkg::SLOT_W-1:0] slot,
                              output logic [slkft_pkg::KEY_W-1:0] key);
        int idx;
        if (recent_slot.size() != 0 && $urandom_range(0, 3) != 0) begin
            idx  = $urandom_range(0, recent_slot.size() - 1);
            slot = recent_slot[idx];
            key  = recent_key[idx];
        end else begin
            slot = pick_slot();
            key  = pick_key();
        end
    endtask

    task automatic lookup_known();
        logic [slkft_pkg::SLOT_W-1:0] slot;
        logic [slkft_pkg::KEY_W-1:0]  key;
        pick_known(slot, key);
        send_request(make_req(slkft_pkg::REQ_LOOKUP, slot, key, key_ok(), rand_frame()));
    endtask

    // Append fresh pairs; a long run overflows the table and exercises the full case.
    task automatic fill_table(input int count);
        logic [slkft_pkg::SLOT_W-1:0] slot;
        logic [slkft_pkg::KEY_W-1:0]  key;
        repeat (count) begin
            slot = pick_slot();
            key  = $urandom();
            remember_pair(slot, key);
            send_request(make_req(slkft_pkg::REQ_STORE, slot, key, 1'b1, rand_frame()));
        end
    endtask

    task automatic random_request();
        logic [slkft_pkg::SLOT_W-1:0] slot;
        logic [slkft_pkg::KEY_W-1:0]  key;
        int                           roll;
        roll = $urandom_range(0, 99);
        if (roll < 38) begin
            lookup_known();
        end else if (roll < 78) begin
            // Half updates of known pairs, half new pairs.
            if ($urandom_range(0, 1) == 0) begin
                pick_known(slot, key);
            end else begin
                slot = pick_slot();
                key  = pick_key();
            end
            remember_pair(slot, key);
            send_request(make_req(slkft_pkg::REQ_STORE, slot, key, key_ok(), rand_frame()));
        end else if (roll < 90) begin
            send_request(make_req(slkft_pkg::REQ_FORGET, pick_slot(), $urandom(),
                                  1'($urandom()), rand_frame()));
        end else if (roll < 93) begin
            send_request(make_req(slkft_pkg::REQ_CLEAR, slkft_pkg::SLOT_W'($urandom()),
                                  $urandom(), 1'($urandom()), rand_frame()));
        end else begin
            // Noise: every field fully random.
            send_request(make_req(2'($urandom_range(0, 3)), slkft_pkg::SLOT_W'($urandom()),
                                  $urandom(), 1'($urandom()), rand_frame()));
        end
    endtask

    task automatic directed_requests();
        // Empty table: nothing to find, nothing to remove.
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd0, '0, 1'b1, '0));
        send_request(make_req(slkft_pkg::REQ_FORGET, 8'd0, '0, 1'b1, '0));
        // Field extremes on both ends.
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd0, '0, 1'b1, '0));
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd255, '1, 1'b1, '1));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd255, '1, 1'b1, '0));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd0, '0, 1'b1, '1));
        // Update in place, then read it back.
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd0, '0, 1'b1, 64'hA5A5_5A5A_C3C3_3C3C));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd0, '0, 1'b1, '0));
        // Slot matches but key does not.
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd0, '1, 1'b1, '0));
        // Invalid key on a present entry, and on a store.
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd255, '1, 1'b0, '0));
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd9, 32'h1357_9BDF, 1'b0, '1));
        // Forget two entries of one slot, one of them the last entry, so the
        // moved-in entry matches too and the hole must be checked again.
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd7, 32'h0000_0011, 1'b1, 64'h11));
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd9, 32'h0000_0022, 1'b1, 64'h22));
        send_request(make_req(slkft_pkg::REQ_STORE, 8'd7, 32'h0000_0033, 1'b1, 64'h33));
        send_request(make_req(slkft_pkg::REQ_FORGET, 8'd7, '1, 1'b0, '1));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd9, 32'h0000_0022, 1'b1, '0));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd7, 32'h0000_0033, 1'b1, '0));
        send_request(make_req(slkft_pkg::REQ_FORGET, 8'd255, '0, 1'b1, '0));
        // Clear ignores every other field.
        send_request(make_req(slkft_pkg::REQ_CLEAR, 8'd123, 32'hDEAD_BEEF, 1'b1, '1));
        send_request(make_req(slkft_pkg::REQ_LOOKUP, 8'd9, 32'h0000_0022, 1'b1, '0));
    endtask

    // Receiver: switch between stretches of stall patterns, and once, well into
    // the run, hold off long enough that the core backs up and stalls its input.
    initial begin : result_stalls
        int mode;
        int span;
        bit held_off;
        held_off = 1'b0;
        @(posedge clk);
        forever begin
            if (!held_off && items_sent >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 48);
                repeat (span) begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= 1'($urandom_range(0, 1));
                        2:       out_stall <= ($urandom_range(0, 3) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int random_goal;
        int roll;
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        directed_requests();

        // Start the random part with a guaranteed overflow of the table.
        random_goal = items_sent + RANDOM_ITEMS;
        fill_table(RECORDS + 3);
        while (items_sent < random_goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                repeat ($urandom_range(1, 12)) random_request();
            end else if (roll < 75) begin
                fill_table($urandom_range(8, RECORDS + 4));
            end else if (roll < 90) begin
                repeat ($urandom_range(4, 16)) lookup_known();
            end else begin
                // Sweep the busy slots, each forget likely removing several entries.
                foreach (slot_pool[i])
                    send_request(make_req(slkft_pkg::REQ_FORGET, slot_pool[i], $urandom(),
                                          1'($urandom()), rand_frame()));
            end
        end
        in_valid <= 1'b0;

        // Drain: wait for every owed result, then give the core time to misbehave.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("slot_keyed_framing_table_core test passed");
        else
            $display("slot_keyed_framing_table_core test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/slkft_pkg.sv
hw/rtl/slkft_ram.sv
hw/rtl/slot_keyed_framing_table_core.sv
tb/sv/slkft_checker.sv
tb/sv/tb_top.sv
